// File: design/srsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_pkg
// Shared constants and register map for the stepper ramp to step period block.
// ----------------------------------------------------------------------------
package srsp_pkg;

  localparam int unsigned ACC_BITS      = 17;
  localparam int unsigned SCALE_BITS    = 32;
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd188495559;

  typedef enum logic [1:0] {
    REG_ACCEL_LEFT  = 2'd0,
    REG_ACCEL_RIGHT = 2'd1,
    REG_PERIOD_SCALE = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

endpackage
`default_nettype wire

// File: design/stepper_ramp_to_step_period.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_to_step_period
// Two-wheel stepper speed ramp with step-timer period output.
//
// Input stream: s_tuser is the request kind (0 tick, 1 load), s_tdata holds
// the two load speeds. A load sets both speeds; a tick adds each wheel's
// acceleration register, clamped to the speed range.
// Output stream: one word per input word with direction, step period
// (scale / max(|speed|,1), saturated) and the updated speed of each wheel.
// Configuration over APB: accel_left at 0x0, accel_right at 0x4,
// period_scale at 0x8. Write only while the block is idle.
// Sequence: an accepted word goes through ST_START and ST_DIV, and through ST_OUT
// when the output register is still full; the next word is taken only once
// the block is back in ST_IDLE. The two bit-serial dividers, one quotient bit
// per cycle over 32 bits, run side by side.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; if the receiver has not taken it when the next result
// is finished, that result is held and s_tready stays low until it drains.
// Reset clears both speeds, the accelerations and restores the default scale.
// ----------------------------------------------------------------------------
module stepper_ramp_to_step_period #(
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned SPEED_BITS  = 25
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  // apb
  input  wire                                        psel,
  input  wire                                        penable,
  input  wire                                        pwrite,
  input  wire logic [srsp_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  wire logic [srsp_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [srsp_pkg::APB_DATA_BITS-1:0]         prdata,
  output logic                                       pready,
  // input stream
  input  wire                                        s_tvalid,
  output logic                                       s_tready,
  // load_speed_left, load_speed_right
  input  wire logic [((2*SPEED_BITS+7)/8)*8-1:0]     s_tdata,
  // req_type
  input  wire logic [0:0]                            s_tuser,
  // output stream
  output logic                                       m_tvalid,
  input  wire                                        m_tready,
  // dir_left, dir_right, period_left, period_right, speed_left_now,
  // speed_right_now
  output logic [((2+2*PERIOD_BITS+2*SPEED_BITS+7)/8)*8-1:0] m_tdata
);
  import srsp_pkg::*;

  localparam int unsigned RW   = 2 + 2*PERIOD_BITS + 2*SPEED_BITS;
  localparam int unsigned M_DW = ((RW + 7) / 8) * 8;

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV, ST_OUT} state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic [M_DW-1:0] m_tdata_q;

  logic signed [ACC_BITS-1:0] accel_l_q, accel_r_q;
  logic [SCALE_BITS-1:0]      scale_q;

  logic signed [SPEED_BITS-1:0] speed_l, speed_r;
  logic [PERIOD_BITS-1:0]       per_l, per_r;
  logic                         busy_l, busy_r;
  logic                         in_acc, div_done, out_free, out_load;
  reg_idx_e                     ridx;

  // configuration
  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_l_q <= '0;
      accel_r_q <= '0;
      scale_q   <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ACCEL_LEFT:   accel_l_q <= pwdata[ACC_BITS-1:0];
        REG_ACCEL_RIGHT:  accel_r_q <= pwdata[ACC_BITS-1:0];
        REG_PERIOD_SCALE: scale_q   <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ACCEL_LEFT:   prdata = APB_DATA_BITS'(accel_l_q);
      REG_ACCEL_RIGHT:  prdata = APB_DATA_BITS'(accel_r_q);
      REG_PERIOD_SCALE: prdata = APB_DATA_BITS'(scale_q);
      default:          prdata = '0;
    endcase
  end

  // datapath
  assign s_tready = (state_q == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  srsp_ramp #(.SPEED_BITS(SPEED_BITS)) u_ramp_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (in_acc),
    .load_i      (s_tuser[0]),
    .load_speed_i(s_tdata[SPEED_BITS-1:0]),
    .accel_i     (accel_l_q),
    .speed_o     (speed_l)
  );

  srsp_ramp #(.SPEED_BITS(SPEED_BITS)) u_ramp_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (in_acc),
    .load_i      (s_tuser[0]),
    .load_speed_i(s_tdata[2*SPEED_BITS-1:SPEED_BITS]),
    .accel_i     (accel_r_q),
    .speed_o     (speed_r)
  );

  srsp_div #(.PERIOD_BITS(PERIOD_BITS), .SPEED_BITS(SPEED_BITS)) u_div_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .scale_i (scale_q),
    .speed_i (speed_l),
    .busy_o  (busy_l),
    .period_o(per_l)
  );

  srsp_div #(.PERIOD_BITS(PERIOD_BITS), .SPEED_BITS(SPEED_BITS)) u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .scale_i (scale_q),
    .speed_i (speed_r),
    .busy_o  (busy_r),
    .period_o(per_r)
  );

  assign div_done = !busy_l && !busy_r;
  assign out_free = !m_tvalid_q || m_tready;
  assign out_load = out_free &&
                    (((state_q == ST_DIV) && div_done) || (state_q == ST_OUT));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= M_DW'({speed_r, speed_l, per_r, per_l, !speed_r[SPEED_BITS-1],
                             !speed_l[SPEED_BITS-1]});
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (s_tvalid) state_q <= ST_START;
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_q <= out_free ? ST_IDLE : ST_OUT;
          end
        end
        ST_OUT:   if (out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_l == busy_r)
    else $error("dividers out of step");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready |-> !busy_l)
    else $error("input taken while divider busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |=> busy_l && (state_q == ST_DIV))
    else $error("divider did not start");

  a_acc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_START))
    else $error("accepted word not started");
`endif

endmodule
`default_nettype wire

// File: design/srsp_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_ramp
// Per-wheel speed register: load or add acceleration, clamped to the range.
// ----------------------------------------------------------------------------
module srsp_ramp #(
  parameter int unsigned SPEED_BITS = 25
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       upd_i,
  input  wire                                       load_i,
  input  wire logic signed [SPEED_BITS-1:0]         load_speed_i,
  input  wire logic signed [srsp_pkg::ACC_BITS-1:0] accel_i,
  output logic signed [SPEED_BITS-1:0]              speed_o
);
  import srsp_pkg::*;

  localparam int unsigned SW = ((SPEED_BITS > ACC_BITS) ? SPEED_BITS : ACC_BITS) + 1;
  localparam logic signed [SW-1:0] SMAX = SW'((64'd1 << (SPEED_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX;

  logic signed [SPEED_BITS-1:0] speed_q, speed_d;
  logic signed [SW-1:0]         sum, ld_x, sel;

  always_comb begin
    sum  = SW'(speed_q) + SW'(accel_i);
    ld_x = SW'(load_speed_i);
    sel  = load_i ? ld_x : sum;
    priority if (sel > SMAX) begin
      speed_d = SMAX[SPEED_BITS-1:0];
    end else if (sel < SMIN) begin
      speed_d = SMIN[SPEED_BITS-1:0];
    end else begin
      speed_d = sel[SPEED_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (upd_i) begin
      speed_q <= speed_d;
    end
  end

  assign speed_o = speed_q;

endmodule
`default_nettype wire

// File: design/srsp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_div
// Bit-serial restoring divider: scale / max(|speed|,1), one quotient bit per
// cycle, result saturated to the period width.
// ----------------------------------------------------------------------------
module srsp_div #(
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned SPEED_BITS  = 25
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         start_i,
  input  wire logic [srsp_pkg::SCALE_BITS-1:0]        scale_i,
  input  wire logic signed [SPEED_BITS-1:0]           speed_i,
  output logic                                        busy_o,
  output logic [PERIOD_BITS-1:0]                      period_o
);
  import srsp_pkg::*;

  localparam int unsigned DW = SPEED_BITS - 1;
  localparam int unsigned CW = $clog2(SCALE_BITS + 1);
  localparam logic [SCALE_BITS:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

  logic                  busy_q;
  logic [CW-1:0]         cnt_q;
  logic [SCALE_BITS-1:0] acc_q;
  logic [DW-1:0]         rem_q, dvs_q;

  logic [SPEED_BITS-1:0] neg;
  logic [DW-1:0]         mag;
  logic [DW:0]           shifted;
  logic [DW+1:0]         trial;
  logic                  ge;

  always_comb begin
    neg     = -speed_i;
    mag     = speed_i[SPEED_BITS-1] ? neg[DW-1:0] : speed_i[DW-1:0];
    shifted = {rem_q, acc_q[SCALE_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = !trial[DW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(SCALE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= scale_i;
      rem_q <= '0;
      dvs_q <= (mag == '0) ? DW'(1) : mag;
    end else if (busy_q) begin
      acc_q <= {acc_q[SCALE_BITS-2:0], ge};
      rem_q <= ge ? trial[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign busy_o   = busy_q;
  assign period_o = ({1'b0, acc_q} > PMAX) ? '1 : acc_q[PERIOD_BITS-1:0];

endmodule
`default_nettype wire
